[rtl/mshe_pkg.sv]
// shared types and constants of the mpeg2 sequence header extractor
package mshe_pkg;

   // start code handling
   localparam logic [23:0] WINDOW_IDLE  = 24'hFF_FFFF;
   localparam logic [23:0] START_PREFIX = 24'h00_0001;
   localparam logic [7:0]  CODE_SEQ_HDR = 8'hB3;
   localparam logic [7:0]  CODE_SEQ_EXT = 8'hB5;

   // header and extension layout
   localparam int HDR_BODY_LEN   = 8;
   localparam int EXT_BODY_LEN   = 6;
   localparam int MATRIX_LEN     = 64;
   localparam int HDR_MARKER_IDX = 6;
   localparam int EXT_MARKER_IDX = 3;
   localparam int BODY_CNT_W     = $clog2(MATRIX_LEN);

   // flag masks
   localparam logic [7:0] HDR_MARKER_MASK = 8'h20;
   localparam logic [7:0] EXT_MARKER_MASK = 8'h01;
   localparam logic [7:0] INTRA_MASK      = 8'h02;
   localparam logic [7:0] NON_INTRA_MASK  = 8'h01;

   // command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // closing status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOHDR  = 2'd1,
      ST_MARKER = 2'd2,
      ST_TRUNC  = 2'd3
   } status_type;

   // work that one input byte leaves for the back end
   typedef struct packed {
      logic       has_code;
      logic       has_byte;
      logic [7:0] data;
      logic       has_status;
      status_type status;
      logic [7:0] length;
   } cmd_type;

endpackage

[rtl/mshe_if.sv]
// valid/ready channels for input bytes and result beats
interface mshe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mshe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_status;
   logic [1:0] status;
   logic [7:0] total_length;
   logic       end_of_run;

   modport source (output valid, output out_byte, output is_status, output status,
                   output total_length, output end_of_run, input ready);
   modport sink   (input valid, input out_byte, input is_status, input status,
                   input total_length, input end_of_run, output ready);
endinterface

[rtl/mpeg2_sequence_header_extractor.sv]
// top level of the mpeg2 sequence header extractor
//
//   channel  dir  modport  beat
//   req_ch   in   sink     one extradata byte with last flag
//   rsp_ch   out  source   one copied byte or the closing status
//
// takes one byte per cycle while the command queue has room
// a start code byte yields four result beats (five with a status) from one
// queue entry; with bytes back to back the queue fills and the input stalls
// at start codes, then one byte and one beat per cycle while the output is ready
// a result beat is written to the queue when its byte is taken and then
// passes through the output register, which presents it to rsp_ch
// reset is synchronous and clears phase state, queue pointers and output valid
// either side may stall on its own; the output register holds a stalled beat
module mpeg2_sequence_header_extractor (
   input  logic       clock,
   input  logic       reset,
   mshe_req_if.sink   req_ch,
   mshe_rsp_if.source rsp_ch
);

   logic              accept;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   mshe_pkg::cmd_type push_cmd;
   mshe_pkg::cmd_type head_cmd;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   // byte classification
   mshe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .push      (push),
      .cmd       (push_cmd)
   );

   // decoupling queue
   mshe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (full),
      .empty    (empty)
   );

   // result beat generation
   mshe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (!empty),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

[rtl/mshe_front.sv]
// front end: start code hunt, header phase tracking, command generation
module mshe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output logic              push,
   output mshe_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_SEARCH_HDR = 3'd0,
      PH_HDR_BODY   = 3'd1,
      PH_INTRA      = 3'd2,
      PH_NONINTRA   = 3'd3,
      PH_SEARCH_EXT = 3'd4,
      PH_EXT_BODY   = 3'd5
   } phase_type;

   localparam int BW = mshe_pkg::BODY_CNT_W;

   phase_type     phase_ff, phase_in;
   logic [23:0]   window_ff, window_in;
   logic [BW-1:0] body_ff, body_in;
   logic          nip_ff, nip_in;
   logic [7:0]    copied_ff, copied_in;
   logic          finished_ff, finished_in;

   logic                 st_hit;
   mshe_pkg::status_type st;
   logic [7:0]           count_now;
   logic [2:0]           n_data;

   // next state and command for the byte on the input
   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      body_in     = body_ff;
      nip_in      = nip_ff;
      copied_in   = copied_ff;
      finished_in = finished_ff;
      st_hit      = 1'b0;
      st          = mshe_pkg::ST_OK;
      cmd         = '0;
      cmd.data    = data_byte;

      if (!finished_ff) begin
         unique case (phase_ff)
            PH_SEARCH_HDR, PH_SEARCH_EXT: begin
               window_in = {window_ff[15:0], data_byte};
               if (window_ff == mshe_pkg::START_PREFIX) begin
                  window_in = mshe_pkg::WINDOW_IDLE;
                  if (phase_ff == PH_SEARCH_HDR) begin
                     if (data_byte == mshe_pkg::CODE_SEQ_HDR) begin
                        cmd.has_code = 1'b1;
                        phase_in     = PH_HDR_BODY;
                        body_in      = '0;
                     end
                  end else if (data_byte == mshe_pkg::CODE_SEQ_EXT) begin
                     cmd.has_code = 1'b1;
                     phase_in     = PH_EXT_BODY;
                     body_in      = '0;
                  end else begin
                     st_hit = 1'b1;
                     st     = mshe_pkg::ST_OK;
                  end
               end
            end
            PH_HDR_BODY: begin
               if (body_ff == BW'(mshe_pkg::HDR_MARKER_IDX) &&
                   (data_byte & mshe_pkg::HDR_MARKER_MASK) == 8'd0) begin
                  st_hit = 1'b1;
                  st     = mshe_pkg::ST_MARKER;
               end else begin
                  cmd.has_byte = 1'b1;
                  body_in      = body_ff + BW'(1);
                  if (body_ff == BW'(mshe_pkg::HDR_BODY_LEN - 1)) begin
                     body_in = '0;
                     nip_in  = |(data_byte & mshe_pkg::NON_INTRA_MASK);
                     if (|(data_byte & mshe_pkg::INTRA_MASK))
                        phase_in = PH_INTRA;
                     else if (|(data_byte & mshe_pkg::NON_INTRA_MASK))
                        phase_in = PH_NONINTRA;
                     else
                        phase_in = PH_SEARCH_EXT;
                  end
               end
            end
            PH_INTRA: begin
               cmd.has_byte = 1'b1;
               body_in      = body_ff + BW'(1);
               if (body_ff == BW'(mshe_pkg::MATRIX_LEN - 1)) begin
                  body_in  = '0;
                  nip_in   = |(data_byte & mshe_pkg::NON_INTRA_MASK);
                  phase_in = (|(data_byte & mshe_pkg::NON_INTRA_MASK)) ?
                             PH_NONINTRA : PH_SEARCH_EXT;
               end
            end
            PH_NONINTRA: begin
               cmd.has_byte = 1'b1;
               body_in      = body_ff + BW'(1);
               if (body_ff == BW'(mshe_pkg::MATRIX_LEN - 1)) begin
                  body_in  = '0;
                  nip_in   = 1'b0;
                  phase_in = PH_SEARCH_EXT;
               end
            end
            PH_EXT_BODY: begin
               if (body_ff == BW'(mshe_pkg::EXT_MARKER_IDX) &&
                   (data_byte & mshe_pkg::EXT_MARKER_MASK) == 8'd0) begin
                  st_hit = 1'b1;
                  st     = mshe_pkg::ST_MARKER;
               end else begin
                  cmd.has_byte = 1'b1;
                  body_in      = body_ff + BW'(1);
                  if (body_ff == BW'(mshe_pkg::EXT_BODY_LEN - 1)) begin
                     st_hit = 1'b1;
                     st     = mshe_pkg::ST_OK;
                  end
               end
            end
            default: begin
               st_hit = 1'b1;
               st     = mshe_pkg::ST_NOHDR;
            end
         endcase

         // input ends with no status yet
         if (!st_hit && last_byte) begin
            st_hit = 1'b1;
            if (phase_in == PH_SEARCH_HDR)
               st = mshe_pkg::ST_NOHDR;
            else if (phase_in == PH_SEARCH_EXT)
               st = mshe_pkg::ST_OK;
            else
               st = mshe_pkg::ST_TRUNC;
         end
      end

      // byte count after this step
      n_data    = cmd.has_code ? 3'd4 : (cmd.has_byte ? 3'd1 : 3'd0);
      count_now = copied_ff + {5'd0, n_data};
      copied_in = count_now;

      cmd.has_status = st_hit;
      cmd.status     = st;
      cmd.length     = (st == mshe_pkg::ST_OK) ? count_now : 8'd0;

      if (st_hit)
         finished_in = 1'b1;

      // end of extradata returns everything to the start
      if (last_byte && (finished_ff || st_hit)) begin
         phase_in    = PH_SEARCH_HDR;
         window_in   = mshe_pkg::WINDOW_IDLE;
         body_in     = '0;
         nip_in      = 1'b0;
         copied_in   = 8'd0;
         finished_in = 1'b0;
      end
   end

   assign push = accept && (cmd.has_code || cmd.has_byte || cmd.has_status);

   // phase state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEARCH_HDR;
         window_ff   <= mshe_pkg::WINDOW_IDLE;
         body_ff     <= '0;
         nip_ff      <= 1'b0;
         copied_ff   <= 8'd0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         body_ff     <= body_in;
         nip_ff      <= nip_in;
         copied_ff   <= copied_in;
         finished_ff <= finished_in;
      end
   end

   // copied bytes never pass the largest legal length
   a_copied_range: assert property (@(posedge clock) disable iff (reset)
      copied_ff <= 8'd150)
      else $error("copied count out of range");

   // a finished run emits no further beats until the last byte
   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !(cmd.has_code || cmd.has_byte || cmd.has_status))
      else $error("beats after the run ended");

   // a start code command only leaves the search phases
   a_code_from_search: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.has_code) |=> (phase_ff == PH_HDR_BODY || phase_ff == PH_EXT_BODY
                                    || $past(last_byte)))
      else $error("start code command outside a search phase");

endmodule

[rtl/mshe_queue.sv]
// short command queue between front and back end
module mshe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mshe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output mshe_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);

   localparam int PW = mshe_pkg::QUEUE_PTR_W;

   mshe_pkg::cmd_type mem_ff [mshe_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]       count_ff;

   assign full     = count_ff == (PW+1)'(mshe_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = mem_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_cmd;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         if (push && !pop)
            count_ff <= count_ff + (PW+1)'(1);
         else if (pop && !push)
            count_ff <= count_ff - (PW+1)'(1);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue underflow");

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

[rtl/mshe_back.sv]
// back end: expands commands into result beats behind an output register
module mshe_back (
   input  logic              clock,
   input  logic              reset,
   input  mshe_pkg::cmd_type head_cmd,
   input  logic              head_valid,
   output logic              pop,
   mshe_rsp_if.source        rsp_ch
);

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       is_status_ff, is_status_in;
   logic [1:0] status_ff, status_in;
   logic [7:0] length_ff, length_in;
   logic [2:0] sub_ff, sub_in;

   logic [2:0] n_data;
   logic [2:0] n_total;
   logic       last_item;
   logic       advance;

   // pick the beat at the current step of the head command
   always_comb begin
      n_data    = head_cmd.has_code ? 3'd4 : (head_cmd.has_byte ? 3'd1 : 3'd0);
      n_total   = n_data + {2'd0, head_cmd.has_status};
      last_item = sub_ff == (n_total - 3'd1);

      out_byte_in  = 8'd0;
      is_status_in = 1'b0;
      status_in    = 2'd0;
      length_in    = 8'd0;
      if (sub_ff < n_data) begin
         if (head_cmd.has_code) begin
            case (sub_ff[1:0])
               2'd0, 2'd1: out_byte_in = 8'h00;
               2'd2:       out_byte_in = 8'h01;
               default:    out_byte_in = head_cmd.data;
            endcase
         end else begin
            out_byte_in = head_cmd.data;
         end
      end else begin
         is_status_in = 1'b1;
         status_in    = head_cmd.status;
         length_in    = head_cmd.length;
      end

      sub_in = last_item ? 3'd0 : sub_ff + 3'd1;
   end

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign pop     = advance && head_valid && last_item;

   // beat valid and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 3'd0;
      end else if (advance) begin
         rsp_valid_ff <= head_valid;
         if (head_valid)
            sub_ff <= sub_in;
      end
   end

   // beat payload
   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         out_byte_ff  <= out_byte_in;
         is_status_ff <= is_status_in;
         status_ff    <= status_in;
         length_ff    <= length_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.is_status    = is_status_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.total_length = length_ff;
   assign rsp_ch.end_of_run   = is_status_ff;

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff <= 3'd4)
      else $error("step counter out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(out_byte_ff)
                                           && $stable(is_status_ff)))
      else $error("stalled beat changed");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> sub_ff == 3'd0)
      else $error("step counter left over without a command");

endmodule
